// ===== hdl/kwm_pkg.sv =====
// Shared types, sizes and the key ordering for the k-way sorted merge.
`default_nettype none

package kwm_pkg;

  localparam int LISTS      = 16;
  localparam int CNT_W      = $clog2(LISTS + 1);
  localparam int ACTIVE_CAP = (LISTS < 16) ? LISTS : 16;

  localparam logic [4:0] NUM_LISTS_RST = 5'd16;

  typedef struct packed {
    logic               valid;
    logic signed [31:0] value;
    logic [3:0]         src;
  } entry_t;

  typedef struct packed {
    logic ins;
    logic pop;
  } cmd_t;

  // Strict ordering: smaller value first, ties to the lower list index.
  function automatic logic key_less(entry_t a, entry_t b);
    return ($signed(a.value) < $signed(b.value)) ||
           ((a.value == b.value) && (a.src < b.src));
  endfunction

endpackage

`default_nettype wire

// ===== hdl/kwm_cell.sv =====
// One cell of the sorted register row: holds one entry and trades with its neighbours.
`default_nettype none

module kwm_cell (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            en,
  input  wire kwm_pkg::cmd_t   cmd,
  input  wire kwm_pkg::entry_t x,
  input  wire kwm_pkg::entry_t left,
  input  wire kwm_pkg::entry_t right,
  input  wire logic            c_left,
  input  wire logic            c_right,
  output logic                 c_own,
  output kwm_pkg::entry_t      q
);
  import kwm_pkg::*;

  logic               vld;
  logic signed [31:0] val;
  logic [3:0]         src;
  entry_t             q_next;

  assign q     = '{valid: vld, value: val, src: src};
  assign c_own = !vld || key_less(x, q);

  // The row stays sorted, so c_own is false on a prefix and true beyond it.
  always_comb begin
    if (cmd.ins && cmd.pop) begin
      q_next = c_right ? (c_own ? q : x) : right;
    end else if (cmd.pop) begin
      q_next = right;
    end else if (cmd.ins) begin
      q_next = c_left ? left : (c_own ? x : q);
    end else begin
      q_next = q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (en) begin
      vld <= q_next.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      val <= q_next.value;
      src <= q_next.src;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/k_way_sorted_merge_top.sv =====
// Top level of the k-way sorted merge: load control, sorted cell row and output register.
// The block takes one transfer per clock cycle and its result, if any, appears in the
// output register in the next cycle; it stalls only while a result waits to be taken. The
// row of cells keeps the held entries sorted with the smallest in cell 0, and every cell
// decides its next entry from its own compare and its neighbours, so an insert and a pop
// of the minimum complete together. The first num_lists transfers, clamped to 1..16,
// load list heads; the transfer completing the load and each after it may yield a result.
`default_nettype none

module k_way_sorted_merge_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [4:0]  cfg_wdata,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,   // value[31:0], list_id[35:32], zero fill
  input  wire logic        s_tuser,   // exhausted
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,   // out_value[31:0], source_list[35:32], zero fill
  output logic             m_tlast
);
  import kwm_pkg::*;

  logic [4:0]       num_lists;
  logic [4:0]       n_clamped;
  logic [CNT_W-1:0] n_eff;
  logic [CNT_W-1:0] loaded;
  logic [CNT_W-1:0] loaded_next;
  logic             accept;
  logic             pop_due;
  cmd_t             cmd;
  entry_t           x;
  entry_t           ent [LISTS];
  logic             c [LISTS];
  logic [LISTS-1:0] vld;
  entry_t           res;
  logic             res_valid;
  logic             res_last;
  logic signed [31:0] out_val;
  logic [3:0]       out_src;

  localparam entry_t EMPTY = '{valid: 1'b0, value: 32'sd0, src: 4'd0};

  always_ff @(posedge clk) begin
    if (rst) begin
      num_lists <= NUM_LISTS_RST;
    end else if (cfg_we) begin
      num_lists <= cfg_wdata;
    end
  end

  always_comb begin
    if (num_lists == 5'd0) begin
      n_clamped = 5'd1;
    end else if (num_lists > 5'(ACTIVE_CAP)) begin
      n_clamped = 5'(ACTIVE_CAP);
    end else begin
      n_clamped = num_lists;
    end
  end

  assign n_eff    = CNT_W'(n_clamped);
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    if (loaded < n_eff) begin
      loaded_next = loaded + CNT_W'(1);
      pop_due     = (loaded_next >= n_eff);
    end else begin
      loaded_next = loaded;
      pop_due     = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      loaded <= '0;
    end else if (accept) begin
      loaded <= loaded_next;
    end
  end

  assign cmd.ins = !s_tuser;
  assign cmd.pop = pop_due;
  assign x       = '{valid: 1'b1, value: $signed(s_tdata[31:0]), src: s_tdata[35:32]};

  for (genvar i = 0; i < LISTS; i++) begin : g_cell
    entry_t left_ent;
    entry_t right_ent;
    logic   c_l;
    logic   c_r;

    if (i == 0) begin : g_first
      assign left_ent = EMPTY;
      assign c_l      = 1'b0;
    end else begin : g_mid_l
      assign left_ent = ent[i-1];
      assign c_l      = c[i-1];
    end

    if (i == LISTS - 1) begin : g_last
      assign right_ent = EMPTY;
      assign c_r       = 1'b1;
    end else begin : g_mid_r
      assign right_ent = ent[i+1];
      assign c_r       = c[i+1];
    end

    kwm_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (accept),
      .cmd     (cmd),
      .x       (x),
      .left    (left_ent),
      .right   (right_ent),
      .c_left  (c_l),
      .c_right (c_r),
      .c_own   (c[i]),
      .q       (ent[i])
    );

    assign vld[i] = ent[i].valid;
  end

  assign res_valid = pop_due && (cmd.ins || ent[0].valid);
  assign res       = (cmd.ins && c[0]) ? x : ent[0];

  always_comb begin
    if (cmd.ins) begin
      res_last = c[0] ? !ent[0].valid : 1'b0;
    end else begin
      res_last = !ent[1].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= res_valid;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res_valid) begin
      out_val <= res.value;
      out_src <= res.src;
      m_tlast <= res_last;
    end
  end

  assign m_tdata = {4'b0000, out_src, out_val};

  // A waiting result blocks the input side.
  a_hold_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !s_tready)
    else $error("input accepted while a result was waiting");

  // Occupied cells always form a prefix of the row.
  a_valid_prefix: assert property (@(posedge clk) disable iff (rst)
    (vld & (vld + LISTS'(1))) == '0)
    else $error("gap in the occupied cells");

  // The two head cells are kept in ascending key order.
  a_sorted_head: assert property (@(posedge clk) disable iff (rst)
    ent[1].valid |-> !key_less(ent[1], ent[0]))
    else $error("head cells out of order");

  // After a transfer that may grow it, the load count never passes the list capacity.
  a_load_bound: assert property (@(posedge clk) disable iff (rst)
    (accept && ($past(loaded) != loaded_next)) |=> (loaded <= CNT_W'(ACTIVE_CAP)))
    else $error("load count beyond the list capacity");

endmodule

`default_nettype wire

// ===== dv/k_way_sorted_merge_top_tb.sv =====
// Self-checking testbench for the k-way sorted merge: directed table, then random merges.
`default_nettype none

module k_way_sorted_merge_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import kwm_pkg::*;

  typedef struct packed {
    logic signed [31:0] value;
    logic [3:0]         list;
    logic               done;
  } head_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic [3:0]         src;
    logic               last;
  } merged_t;

  typedef struct packed {
    logic               is_cfg;
    logic [4:0]         lists;
    logic signed [31:0] value;
    logic [3:0]         list;
    logic               done;
    logic               typed;
    logic               t_got;
    logic signed [31:0] t_value;
    logic [3:0]         t_src;
    logic               t_last;
  } dir_row_t;

  localparam int DIR_ROWS = 21;
  localparam int PHASES   = 8;
  localparam int PHASE_ITEMS = 229;
  localparam int LONG_HOLD = 300;
  localparam logic signed [31:0] VMAX = 32'sh7FFFFFFF;
  localparam logic signed [31:0] VMIN = 32'sh80000000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [4:0]  cfg_wdata = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;   // value[31:0], list_id[35:32], zero fill
  logic        s_tuser = 1'b0; // exhausted
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;        // out_value[31:0], source_list[35:32], zero fill
  logic        m_tlast;

  k_way_sorted_merge_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  logic signed [31:0] held_val [LISTS];
  logic [3:0]         held_src [LISTS];
  logic               held_vld [LISTS];
  int                 heads_loaded = 0;
  logic [4:0]         lists_reg = NUM_LISTS_RST;
  logic signed [31:0] last_val = '0;
  logic [3:0]         last_src = '0;

  merged_t merged_q [$];
  dir_row_t dir_tab [DIR_ROWS];

  logic quiet = 1'b0;
  int   heads_sent = 0;
  int   results_seen = 0;
  int   settings_used = 0;
  int   bad_count = 0;

  initial begin
    for (int i = 0; i < LISTS; i++) held_vld[i] = 1'b0;
  end

  function automatic int lists_in_use();
    int n;
    n = lists_reg;
    if (n < 1) n = 1;
    if (n > ACTIVE_CAP) n = ACTIVE_CAP;
    return n;
  endfunction

  function automatic int held_count();
    int c;
    c = 0;
    for (int i = 0; i < LISTS; i++) if (held_vld[i]) c++;
    return c;
  endfunction

  // Inserts the transfer unless it marks its list exhausted, and pops the minimum once the load is complete.
  task automatic merge_predict(input head_t h, output logic got, output merged_t r);
    int  n;
    int  best;
    logic placed;
    n = lists_in_use();
    got = 1'b0;
    r = '0;
    placed = 1'b0;
    if (!h.done) begin
      for (int i = 0; i < LISTS; i++) begin
        if (!placed && !held_vld[i]) begin
          held_vld[i] = 1'b1;
          held_val[i] = h.value;
          held_src[i] = h.list;
          placed = 1'b1;
        end
      end
    end
    if (heads_loaded < n) begin
      heads_loaded++;
      if (heads_loaded < n) return;
    end
    best = -1;
    for (int i = 0; i < LISTS; i++) begin
      if (held_vld[i]) begin
        if (best < 0) best = i;
        else if (held_val[i] < held_val[best] ||
                 (held_val[i] == held_val[best] && held_src[i] < held_src[best])) best = i;
      end
    end
    if (best < 0) return;
    held_vld[best] = 1'b0;
    got = 1'b1;
    r.value = held_val[best];
    r.src = held_src[best];
    r.last = (held_count() == 0);
    last_val = r.value;
    last_src = r.src;
  endtask

  function automatic logic signed [31:0] climb(logic signed [31:0] base, int unsigned span);
    longint t;
    t = longint'(base) + longint'($urandom_range(0, span));
    if (t > longint'(VMAX)) t = longint'(VMAX);
    return t[31:0];
  endfunction

  // Heads in list order while loading, then mostly the last output's successor, or noise on any list.
  function automatic head_t next_head(logic draining);
    head_t h;
    logic  may_end;
    may_end = draining || (held_count() > 8 && $urandom_range(0, 4) == 0);
    if (heads_loaded < lists_in_use()) begin
      h.list = heads_loaded[3:0];
      h.done = ($urandom_range(0, 9) == 0);
      h.value = ($urandom_range(0, 3) == 0) ? $signed($urandom) : climb(last_val, 5000);
    end else if ($urandom_range(0, 9) == 0) begin
      h.list = 4'($urandom_range(0, 15));
      h.done = may_end && ($urandom_range(0, 3) == 0);
      h.value = $signed($urandom);
    end else begin
      h.list = last_src;
      h.done = may_end && ($urandom_range(0, 5) == 0);
      h.value = ($urandom_range(0, 3) == 0) ? last_val : climb(last_val, 2000);
    end
    return h;
  endfunction

  task automatic offer(input head_t h, input int gap, output logic got, output merged_t r);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {4'b0, h.list, h.value};
    s_tuser <= h.done;
    do @(posedge clk); while (!s_tready);
    heads_sent++;
    merge_predict(h, got, r);
  endtask

  task automatic write_lists(input logic [4:0] v);
    while (merged_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    lists_reg = v;
    settings_used++;
    cfg_we <= 1'b0;
  endtask

  function automatic void report_bad(string what, merged_t want, merged_t seen);
    bad_count++;
    if (bad_count <= 10)
      $display("%t %s: expected value %0d list %0d last %0d, got value %0d list %0d last %0d",
               $realtime, what, want.value, want.src, want.last,
               seen.value, seen.src, seen.last);
  endfunction

  initial begin
    dir_tab = '{
      '{1'b1, 5'd0,  32'sd0,        4'd0,  1'b0, 1'b0, 1'b0, 32'sd0, 4'd0,  1'b0},
      '{1'b0, 5'd0,  32'sd5,        4'd3,  1'b0, 1'b1, 1'b1, 32'sd5, 4'd3,  1'b1},
      '{1'b0, 5'd0,  -32'sd1,       4'd3,  1'b1, 1'b1, 1'b0, 32'sd0, 4'd0,  1'b0},
      '{1'b0, 5'd0,  VMAX,          4'd15, 1'b0, 1'b1, 1'b1, VMAX,   4'd15, 1'b1},
      '{1'b0, 5'd0,  VMIN,          4'd0,  1'b0, 1'b1, 1'b1, VMIN,   4'd0,  1'b1},
      '{1'b0, 5'd0,  32'sd0,        4'd0,  1'b1, 1'b1, 1'b0, 32'sd0, 4'd0,  1'b0},
      '{1'b1, 5'd4,  32'sd0,        4'd0,  1'b0, 1'b0, 1'b0, 32'sd0, 4'd0,  1'b0},
      '{1'b0, 5'd0,  32'sd10,       4'd1,  1'b0, 1'b1, 1'b0, 32'sd0, 4'd0,  1'b0},
      '{1'b0, 5'd0,  -32'sd1,       4'd2,  1'b0, 1'b1, 1'b0, 32'sd0, 4'd0,  1'b0},
      '{1'b0, 5'd0,  32'sd10,       4'd0,  1'b0, 1'b1, 1'b1, -32'sd1, 4'd2, 1'b0},
      '{1'b0, 5'd0,  32'sd10,       4'd2,  1'b0, 1'b0, 1'b0, 32'sd0, 4'd0,  1'b0},
      '{1'b0, 5'd0,  32'sh12345678, 4'd0,  1'b1, 1'b0, 1'b0, 32'sd0, 4'd0,  1'b0},
      '{1'b0, 5'd0,  32'sd0,        4'd1,  1'b1, 1'b0, 1'b0, 32'sd0, 4'd0,  1'b0},
      '{1'b0, 5'd0,  32'sd20,       4'd9,  1'b0, 1'b0, 1'b0, 32'sd0, 4'd0,  1'b0},
      '{1'b1, 5'd8,  32'sd0,        4'd0,  1'b0, 1'b0, 1'b0, 32'sd0, 4'd0,  1'b0},
      '{1'b0, 5'd0,  VMAX,          4'd4,  1'b0, 1'b0, 1'b0, 32'sd0, 4'd0,  1'b0},
      '{1'b0, 5'd0,  32'sh55555555, 4'd5,  1'b1, 1'b0, 1'b0, 32'sd0, 4'd0,  1'b0},
      '{1'b0, 5'd0,  VMIN,          4'd6,  1'b0, 1'b0, 1'b0, 32'sd0, 4'd0,  1'b0},
      '{1'b0, 5'd0,  32'sd7,        4'd7,  1'b0, 1'b0, 1'b0, 32'sd0, 4'd0,  1'b0},
      '{1'b0, 5'd0,  -32'sd3,       4'd6,  1'b0, 1'b0, 1'b0, 32'sd0, 4'd0,  1'b0},
      '{1'b0, 5'd0,  -32'sd3,       4'd3,  1'b0, 1'b0, 1'b0, 32'sd0, 4'd0,  1'b0}
    };
  end

  initial begin
    logic [4:0] phase_lists [PHASES];
    head_t      h;
    merged_t    r;
    logic       got;
    phase_lists = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd12, 5'd5, 5'd20, 5'd2};
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int k = 0; k < DIR_ROWS; k++) begin
      if (dir_tab[k].is_cfg) begin
        s_tvalid <= 1'b0;
        write_lists(dir_tab[k].lists);
      end else begin
        h.value = dir_tab[k].value;
        h.list = dir_tab[k].list;
        h.done = dir_tab[k].done;
        offer(h, $urandom_range(0, 6), got, r);
        if (dir_tab[k].typed) begin
          got = dir_tab[k].t_got;
          r = {dir_tab[k].t_value, dir_tab[k].t_src, dir_tab[k].t_last};
        end
        if (got) merged_q.push_back(r);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      s_tvalid <= 1'b0;
      write_lists(phase_lists[p]);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        quiet = ((k % 120) < 30);
        h = next_head(p == PHASES - 1);
        offer(h, quiet ? 0 : $urandom_range(0, 6), got, r);
        if (got) merged_q.push_back(r);
      end
    end
    s_tvalid <= 1'b0;
    quiet = 1'b0;

    while (merged_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("Sent %0d list elements under %0d list-count settings and checked %0d results.",
             heads_sent, settings_used, results_seen);
    $display("Mismatches or unexpected results: %0d.", bad_count);
    if (bad_count == 0 && merged_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Output side: random back-pressure, with two long holds that stall the input side.
  initial begin
    int      stall;
    merged_t seen;
    merged_t want;
    wait (!rst);
    @(posedge clk);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 6);
      if (results_seen == 400 || results_seen == 1300) stall = LONG_HOLD;
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      results_seen++;
      seen.value = m_tdata[31:0];
      seen.src = m_tdata[35:32];
      seen.last = m_tlast;
      if (merged_q.size() == 0) begin
        report_bad("unexpected result", '0, seen);
      end else begin
        want = merged_q.pop_front();
        if (seen != want) report_bad("mismatch", want, seen);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Timed out with %0d results still outstanding.", merged_q.size());
    $display("TB_ERROR");
    $finish;
  end

endmodule

`default_nettype wire
